@@ design/masked_neighbour_mean_filter_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the masked neighbour mean filter
// Same-cycle and next-cycle implication checks, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MASKED_NEIGHBOUR_MEAN_FILTER_ASSERT_SVH
`define MASKED_NEIGHBOUR_MEAN_FILTER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define MNMF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mnmf assertion failed");

// antecedent implies consequent in the next cycle
`define MNMF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mnmf assertion failed");

`endif

@@ design/mnmf_pkg.sv @@
// ----------------------------------------------------------------------------
// mnmf_pkg
// Types and constants shared by the masked neighbour mean filter.
// ----------------------------------------------------------------------------
package mnmf_pkg;

   // frame geometry and field widths
   localparam int MAX_ROW_WIDTH = 1024;
   localparam int PIXEL_BITS    = 8;
   localparam int CELL_BITS     = PIXEL_BITS + 1;          // value plus outside flag
   localparam int ADDR_BITS     = $clog2(MAX_ROW_WIDTH);
   localparam int WIDTH_BITS    = 11;
   localparam int MASK_BITS     = 8;
   localparam int GAIN_BITS     = 12;
   localparam int GAIN_FRAC     = 8;
   localparam int ROW_BITS      = 16;
   localparam int OUT_BITS      = 8;

   // neighbourhood arithmetic
   localparam int NB_COUNT   = 8;
   localparam int WIN_CELLS  = 9;
   localparam int SUM_BITS   = PIXEL_BITS + $clog2(NB_COUNT);
   localparam int CNT_BITS   = $clog2(NB_COUNT) + 1;
   localparam int DIV_STEPS  = SUM_BITS;
   localparam int STEP_BITS  = $clog2(DIV_STEPS);
   localparam int PROD_BITS  = PIXEL_BITS + GAIN_BITS;

   // configuration port
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [1:0] {
      REG_ROW_WIDTH      = 2'd0,
      REG_NEIGHBOUR_MASK = 2'd1,
      REG_GAIN           = 2'd2
   } csr_reg_type;

   localparam logic [WIDTH_BITS-1:0] ROW_WIDTH_RESET = WIDTH_BITS'(1024);
   localparam logic [MASK_BITS-1:0]  MASK_RESET      = MASK_BITS'(255);
   localparam logic [GAIN_BITS-1:0]  GAIN_RESET      = GAIN_BITS'(256);

   // command codes
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   typedef logic [CELL_BITS-1:0] cell_type;
   localparam cell_type OUTSIDE_CELL = {1'b1, {PIXEL_BITS{1'b0}}};

   // window position of each neighbour, order NW,N,NE,W,E,SW,S,SE
   localparam int NB_POS [NB_COUNT] = '{0, 1, 2, 3, 5, 6, 7, 8};
   // neighbours that look one column left / right
   localparam logic [NB_COUNT-1:0] NB_WEST = 8'b0010_1001;
   localparam logic [NB_COUNT-1:0] NB_EAST = 8'b1001_0100;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_SUM,
      S_DIV,
      S_MUL,
      S_OUT
   } fsm_state_type;

   typedef struct packed {
      logic                  cmd;
      logic [PIXEL_BITS-1:0] pixel;
   } req_payload_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] value;
      logic                last;
   } rsp_payload_type;

endpackage

@@ design/mnmf_ram.sv @@
// ----------------------------------------------------------------------------
// mnmf_ram
// Generic single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module mnmf_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/masked_neighbour_mean_filter.sv @@
// ----------------------------------------------------------------------------
// masked_neighbour_mean_filter
// Masked 3x3 neighbourhood mean over a raster pixel stream, with gain and
// saturation. Two row stores in RAM feed a 3x3 window of registers.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  req_      in         req_valid / req_stall     req_data (cmd, pixel)
//  rsp_      out        rsp_valid / rsp_stall     rsp_data (value, last)
//  config    in         psel/penable/pwrite/pready  paddr, pwdata, prdata
//
//  One transaction at a time. An item with no result passes accept and row
//  store read, then write back and window shift; an ignored flush is dropped.
//  A result then takes the sum, the bit-serial divider, multiply and output.
//  The output register holds a result under rsp_stall while the next item
//  is taken; the sequencer waits only if a second result is ready.
//  Reset is synchronous; the row stores are not cleared and need no sweep.
// ----------------------------------------------------------------------------
module masked_neighbour_mean_filter (
   input  logic                                 clock,
   input  logic                                 reset,
   // input channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  mnmf_pkg::req_payload_type            req_data,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output mnmf_pkg::rsp_payload_type            rsp_data,
   // configuration
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [mnmf_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [mnmf_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [mnmf_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                 pready
);

   `include "masked_neighbour_mean_filter_assert.svh"

   // configuration registers
   logic [mnmf_pkg::WIDTH_BITS-1:0] row_width_ff;
   logic [mnmf_pkg::MASK_BITS-1:0]  mask_ff;
   logic [mnmf_pkg::GAIN_BITS-1:0]  gain_ff;
   mnmf_pkg::csr_reg_type           csr_sel;
   logic                            csr_wr;

   // sequencer and counters
   mnmf_pkg::fsm_state_type          state_ff, state_in;
   logic [mnmf_pkg::ADDR_BITS-1:0]   col_ff, col_in;
   logic [mnmf_pkg::ROW_BITS-1:0]    row_ff, row_in;
   logic [mnmf_pkg::WIDTH_BITS-1:0]  warm_ff, warm_in;
   logic [mnmf_pkg::WIDTH_BITS-1:0]  flush_ff, flush_in;
   mnmf_pkg::cell_type               win_ff [mnmf_pkg::WIN_CELLS];
   mnmf_pkg::cell_type               win_in [mnmf_pkg::WIN_CELLS];

   // latched item and result control
   logic                             cmd_ff, cmd_in;
   logic [mnmf_pkg::PIXEL_BITS-1:0]  pixel_ff, pixel_in;
   logic [mnmf_pkg::ADDR_BITS-1:0]   addr_ff, addr_in;
   logic                             last_ff, last_in;
   logic                             cc_first_ff, cc_first_in;
   logic                             cc_last_ff, cc_last_in;

   // arithmetic datapath
   logic [mnmf_pkg::CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [mnmf_pkg::CNT_BITS-1:0]    divisor_ff, divisor_in;
   logic [mnmf_pkg::CNT_BITS-1:0]    rem_ff, rem_in;
   logic [mnmf_pkg::SUM_BITS-1:0]    dvd_ff, dvd_in;
   logic [mnmf_pkg::STEP_BITS-1:0]   step_ff, step_in;
   logic [mnmf_pkg::PROD_BITS-1:0]   prod_ff, prod_in;

   // output register
   logic                             rsp_valid_ff, rsp_valid_in;
   mnmf_pkg::rsp_payload_type        rsp_data_ff, rsp_data_in;

   // row store ports
   logic                             ram_rd;
   logic                             ram_wr;
   logic [mnmf_pkg::ADDR_BITS-1:0]   ram_addr;
   mnmf_pkg::cell_type               upper_rd, middle_rd;
   mnmf_pkg::cell_type               upper_wd, middle_wd;

   // helpers
   logic [mnmf_pkg::WIDTH_BITS-1:0]  eff_w, w_m1, w_p1;
   logic [mnmf_pkg::ADDR_BITS-1:0]   col_now;
   logic [mnmf_pkg::WIDTH_BITS-1:0]  col_next;
   logic [mnmf_pkg::ADDR_BITS-1:0]   cc;
   logic                             ignore;
   logic                             emit;
   logic [mnmf_pkg::WIDTH_BITS-1:0]  flush_next;
   logic                             last_now;
   mnmf_pkg::cell_type               top_cell, mid_cell, new_cell;
   logic [mnmf_pkg::SUM_BITS-1:0]    nb_sum;
   logic [mnmf_pkg::CNT_BITS-1:0]    nb_cnt;
   logic [mnmf_pkg::CNT_BITS:0]      trial;
   logic                             q_bit;
   logic [mnmf_pkg::OUT_BITS-1:0]    sat_value;

   // ---------------------------------------------------------------------
   // configuration port
   // ---------------------------------------------------------------------
   assign csr_sel = mnmf_pkg::csr_reg_type'(paddr[3:2]);
   assign csr_wr  = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= mnmf_pkg::ROW_WIDTH_RESET;
         mask_ff      <= mnmf_pkg::MASK_RESET;
         gain_ff      <= mnmf_pkg::GAIN_RESET;
      end else if (csr_wr) begin
         unique case (csr_sel)
            mnmf_pkg::REG_ROW_WIDTH:      row_width_ff <= pwdata[mnmf_pkg::WIDTH_BITS-1:0];
            mnmf_pkg::REG_NEIGHBOUR_MASK: mask_ff      <= pwdata[mnmf_pkg::MASK_BITS-1:0];
            mnmf_pkg::REG_GAIN:           gain_ff      <= pwdata[mnmf_pkg::GAIN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         mnmf_pkg::REG_ROW_WIDTH:
            prdata = mnmf_pkg::CSR_DATA_BITS'(row_width_ff);
         mnmf_pkg::REG_NEIGHBOUR_MASK:
            prdata = mnmf_pkg::CSR_DATA_BITS'(mask_ff);
         mnmf_pkg::REG_GAIN:
            prdata = mnmf_pkg::CSR_DATA_BITS'(gain_ff);
         default:
            prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // effective row width: 0 acts as 1, clamp at the store depth
   // ---------------------------------------------------------------------
   always_comb begin
      if (row_width_ff == '0) begin
         eff_w = mnmf_pkg::WIDTH_BITS'(1);
      end else if (row_width_ff > mnmf_pkg::WIDTH_BITS'(mnmf_pkg::MAX_ROW_WIDTH)) begin
         eff_w = mnmf_pkg::WIDTH_BITS'(mnmf_pkg::MAX_ROW_WIDTH);
      end else begin
         eff_w = row_width_ff;
      end
   end

   assign w_m1 = eff_w - mnmf_pkg::WIDTH_BITS'(1);
   assign w_p1 = eff_w + mnmf_pkg::WIDTH_BITS'(1);

   // column used by an incoming item (wraps if the width shrank)
   assign col_now = ({1'b0, col_ff} >= eff_w) ? '0 : col_ff;
   assign ignore  = (req_data.cmd == mnmf_pkg::CMD_FLUSH) && (row_ff == '0)
                    && (col_ff == '0) && (warm_ff == '0);

   // ---------------------------------------------------------------------
   // row stores; read at accept, written back in the following cycle, so
   // two items never touch the same entry in overlapping cycles
   // ---------------------------------------------------------------------
   assign ram_addr  = (state_ff == mnmf_pkg::S_IDLE) ? col_now : addr_ff;
   assign ram_rd    = (state_ff == mnmf_pkg::S_IDLE) && req_valid && !ignore;
   assign ram_wr    = (state_ff == mnmf_pkg::S_READ);
   assign upper_wd  = mid_cell;
   assign middle_wd = new_cell;

   mnmf_ram #(
      .WIDTH (mnmf_pkg::CELL_BITS),
      .DEPTH (mnmf_pkg::MAX_ROW_WIDTH)
   ) u_upper_ram (
      .clock   (clock),
      .rd_en   (ram_rd),
      .wr_en   (ram_wr),
      .addr    (ram_addr),
      .wr_data (upper_wd),
      .rd_data (upper_rd)
   );

   mnmf_ram #(
      .WIDTH (mnmf_pkg::CELL_BITS),
      .DEPTH (mnmf_pkg::MAX_ROW_WIDTH)
   ) u_middle_ram (
      .clock   (clock),
      .rd_en   (ram_rd),
      .wr_en   (ram_wr),
      .addr    (ram_addr),
      .wr_data (middle_wd),
      .rd_data (middle_rd)
   );

   // ---------------------------------------------------------------------
   // window column entering this cycle; rows above the frame are outside
   // ---------------------------------------------------------------------
   assign new_cell = (cmd_ff == mnmf_pkg::CMD_FLUSH) ? mnmf_pkg::OUTSIDE_CELL
                                                     : {1'b0, pixel_ff};
   assign top_cell = (row_ff < mnmf_pkg::ROW_BITS'(2)) ? mnmf_pkg::OUTSIDE_CELL : upper_rd;
   assign mid_cell = (row_ff == '0) ? mnmf_pkg::OUTSIDE_CELL : middle_rd;

   // result exists once warm and the centre (next window slot 4) is inside
   assign emit       = (warm_ff >= w_p1) && !win_ff[5][mnmf_pkg::PIXEL_BITS];
   assign flush_next = (cmd_ff == mnmf_pkg::CMD_FLUSH)
                       ? ((flush_ff < w_p1) ? flush_ff + mnmf_pkg::WIDTH_BITS'(1) : flush_ff)
                       : '0;
   assign last_now   = (cmd_ff == mnmf_pkg::CMD_FLUSH) && (flush_next >= w_p1);
   assign cc         = (addr_ff == '0) ? w_m1[mnmf_pkg::ADDR_BITS-1:0]
                                       : addr_ff - mnmf_pkg::ADDR_BITS'(1);
   assign col_next   = {1'b0, addr_ff} + mnmf_pkg::WIDTH_BITS'(1);

   // ---------------------------------------------------------------------
   // masked neighbour sum and count over the registered window
   // ---------------------------------------------------------------------
   always_comb begin
      nb_sum = '0;
      nb_cnt = '0;
      for (int i = 0; i < mnmf_pkg::NB_COUNT; i++) begin
         if (mask_ff[i]
             && !(mnmf_pkg::NB_WEST[i] && cc_first_ff)
             && !(mnmf_pkg::NB_EAST[i] && cc_last_ff)
             && !win_ff[mnmf_pkg::NB_POS[i]][mnmf_pkg::PIXEL_BITS]) begin
            nb_sum = nb_sum
                     + mnmf_pkg::SUM_BITS'(win_ff[mnmf_pkg::NB_POS[i]][mnmf_pkg::PIXEL_BITS-1:0]);
            nb_cnt = nb_cnt + mnmf_pkg::CNT_BITS'(1);
         end
      end
   end

   // restoring divider step, one quotient bit per cycle
   assign trial = {rem_ff, dvd_ff[mnmf_pkg::SUM_BITS-1]};
   assign q_bit = (trial >= {1'b0, divisor_ff});

   // floor of the 12.8 product, saturated
   assign sat_value = (prod_ff[mnmf_pkg::PROD_BITS-1:mnmf_pkg::GAIN_FRAC + mnmf_pkg::OUT_BITS] != '0)
                      ? '1
                      : prod_ff[mnmf_pkg::GAIN_FRAC + mnmf_pkg::OUT_BITS - 1:mnmf_pkg::GAIN_FRAC];

   // ---------------------------------------------------------------------
   // sequencer: next state and datapath updates
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      warm_in      = warm_ff;
      flush_in     = flush_ff;
      win_in       = win_ff;
      cmd_in       = cmd_ff;
      pixel_in     = pixel_ff;
      addr_in      = addr_ff;
      last_in      = last_ff;
      cc_first_in  = cc_first_ff;
      cc_last_in   = cc_last_ff;
      cnt_in       = cnt_ff;
      divisor_in   = divisor_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      step_in      = step_ff;
      prod_in      = prod_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         // take an item and start the row store read
         mnmf_pkg::S_IDLE: begin
            if (req_valid && !ignore) begin
               cmd_in   = req_data.cmd;
               pixel_in = req_data.pixel;
               addr_in  = col_now;
               state_in = mnmf_pkg::S_READ;
            end
         end

         // row data back: shift window, step counters, write stores
         mnmf_pkg::S_READ: begin
            for (int r = 0; r < 3; r++) begin
               win_in[r*3]     = win_ff[r*3 + 1];
               win_in[r*3 + 1] = win_ff[r*3 + 2];
            end
            win_in[2] = top_cell;
            win_in[5] = mid_cell;
            win_in[8] = new_cell;

            if (warm_ff < w_p1) begin
               warm_in = warm_ff + mnmf_pkg::WIDTH_BITS'(1);
            end
            flush_in    = flush_next;
            last_in     = last_now;
            cc_first_in = (cc == '0);
            cc_last_in  = ({1'b0, cc} == w_m1);

            if (col_next >= eff_w) begin
               col_in = '0;
               if (row_ff != '1) begin
                  row_in = row_ff + mnmf_pkg::ROW_BITS'(1);
               end
            end else begin
               col_in = col_next[mnmf_pkg::ADDR_BITS-1:0];
            end

            // frame end: counters back to reset, window after the result
            if (last_now) begin
               col_in   = '0;
               row_in   = '0;
               warm_in  = '0;
               flush_in = '0;
               if (!emit) begin
                  for (int k = 0; k < mnmf_pkg::WIN_CELLS; k++) begin
                     win_in[k] = mnmf_pkg::OUTSIDE_CELL;
                  end
               end
            end

            state_in = emit ? mnmf_pkg::S_SUM : mnmf_pkg::S_IDLE;
         end

         // neighbour sum and count, divider setup
         mnmf_pkg::S_SUM: begin
            cnt_in     = nb_cnt;
            rem_in     = '0;
            step_in    = '0;
            dvd_in     = (nb_cnt == '0) ? '0 : nb_sum;
            divisor_in = (nb_cnt == '0) ? mnmf_pkg::CNT_BITS'(1) : nb_cnt;
            if (last_ff) begin
               for (int k = 0; k < mnmf_pkg::WIN_CELLS; k++) begin
                  win_in[k] = mnmf_pkg::OUTSIDE_CELL;
               end
            end
            state_in = mnmf_pkg::S_DIV;
         end

         // truncating division by the neighbour count
         mnmf_pkg::S_DIV: begin
            rem_in  = q_bit ? mnmf_pkg::CNT_BITS'(trial - {1'b0, divisor_ff})
                            : trial[mnmf_pkg::CNT_BITS-1:0];
            dvd_in  = {dvd_ff[mnmf_pkg::SUM_BITS-2:0], q_bit};
            step_in = step_ff + mnmf_pkg::STEP_BITS'(1);
            if (step_ff == mnmf_pkg::STEP_BITS'(mnmf_pkg::DIV_STEPS - 1)) begin
               state_in = mnmf_pkg::S_MUL;
            end
         end

         // average times gain
         mnmf_pkg::S_MUL: begin
            prod_in  = dvd_ff[mnmf_pkg::PIXEL_BITS-1:0] * gain_ff;
            state_in = mnmf_pkg::S_OUT;
         end

         // hand the result to the output register once it is free
         mnmf_pkg::S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in.value = sat_value;
               rsp_data_in.last  = last_ff;
               rsp_valid_in      = 1'b1;
               state_in          = mnmf_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = mnmf_pkg::S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mnmf_pkg::S_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         warm_ff      <= '0;
         flush_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < mnmf_pkg::WIN_CELLS; k++) begin
            win_ff[k] <= mnmf_pkg::OUTSIDE_CELL;
         end
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         warm_ff      <= warm_in;
         flush_ff     <= flush_in;
         rsp_valid_ff <= rsp_valid_in;
         win_ff       <= win_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      pixel_ff    <= pixel_in;
      addr_ff     <= addr_in;
      last_ff     <= last_in;
      cc_first_ff <= cc_first_in;
      cc_last_ff  <= cc_last_in;
      cnt_ff      <= cnt_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
      dvd_ff      <= dvd_in;
      step_ff     <= step_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != mnmf_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   // an accepted item that is not dropped goes to the store read
   `MNMF_ASSERT_NEXT(a_accept_reads, clock, reset, req_valid && !req_stall && !ignore, state_ff == mnmf_pkg::S_READ)
   // a waiting result is never overwritten by the next one
   `MNMF_ASSERT_NEXT(a_out_waits, clock, reset, (state_ff == mnmf_pkg::S_OUT) && rsp_valid_ff && rsp_stall, state_ff == mnmf_pkg::S_OUT)
   // no usable neighbour gives a zero average
   `MNMF_ASSERT_IMPL(a_empty_mask_zero, clock, reset, (state_ff == mnmf_pkg::S_MUL) && (cnt_ff == '0), dvd_ff == '0)
   // a new result only comes from the output state
   `MNMF_ASSERT_IMPL(a_result_source, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == mnmf_pkg::S_OUT)

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - masked neighbour mean filter testbench
// Streams raster frames through the filter under several register settings
// and random idling on both channels. A scoreboard class keeps its own copy
// of the line stores, the 3x3 window and the raster position, predicts each
// filtered value at input acceptance and compares the results in order.
// ----------------------------------------------------------------------------
module tb;
   import mnmf_pkg::*;

   // rough number of input transactions for the whole run
   localparam int ITEM_TARGET = 1550;

   // neighbours whose column lies left / right of the center
   localparam logic [NB_COUNT-1:0] LOOKS_WEST = 8'b0010_1001;
   localparam logic [NB_COUNT-1:0] LOOKS_EAST = 8'b1001_0100;

   // predicts filtered values and holds the ones not yet returned
   class neighbour_mean_scoreboard;
      logic [WIDTH_BITS-1:0] row_width;
      logic [MASK_BITS-1:0]  nb_mask;
      logic [GAIN_BITS-1:0]  gain;
      cell_type              upper_line [MAX_ROW_WIDTH];
      cell_type              middle_line [MAX_ROW_WIDTH];
      cell_type              win [WIN_CELLS];
      int unsigned           col_pos, warm_cnt, flush_cnt;
      logic [ROW_BITS-1:0]   row_pos;
      rsp_payload_type       pending_means [$];
      int                    errors, checked, frames_done;

      function new();
         row_width = ROW_WIDTH_RESET;
         nb_mask   = MASK_RESET;
         gain      = GAIN_RESET;
         foreach (upper_line[k]) begin
            upper_line[k]  = '0;
            middle_line[k] = '0;
         end
         restart_frame();
         errors      = 0;
         checked     = 0;
         frames_done = 0;
      endfunction

      function void restart_frame();
         foreach (win[k]) win[k] = OUTSIDE_CELL;
         col_pos   = 0;
         row_pos   = '0;
         warm_cnt  = 0;
         flush_cnt = 0;
      endfunction

      function int unsigned eff_width();
         if (row_width == 0) return 1;
         if (row_width > MAX_ROW_WIDTH) return MAX_ROW_WIDTH;
         return row_width;
      endfunction

      function void set_reg(csr_reg_type r, logic [CSR_DATA_BITS-1:0] v);
         case (r)
            REG_ROW_WIDTH:      row_width = v[WIDTH_BITS-1:0];
            REG_NEIGHBOUR_MASK: nb_mask   = v[MASK_BITS-1:0];
            REG_GAIN:           gain      = v[GAIN_BITS-1:0];
            default: ;
         endcase
      endfunction

      function logic [CSR_DATA_BITS-1:0] reg_value(csr_reg_type r);
         case (r)
            REG_ROW_WIDTH:      return CSR_DATA_BITS'(row_width);
            REG_NEIGHBOUR_MASK: return CSR_DATA_BITS'(nb_mask);
            default:            return CSR_DATA_BITS'(gain);
         endcase
      endfunction

      // advance one accepted item; returns 0 when the item is dropped
      function bit note_item(req_payload_type item);
         int unsigned w, c, cc, sum, cnt, avg, prod;
         int          r, i;
         cell_type    in_pix, top, mid, v;
         bit          emit, fin;
         rsp_payload_type res;
         w = eff_width();
         // flush at the very start of a frame does nothing
         if (item.cmd == CMD_FLUSH && row_pos == 0 && col_pos == 0 && warm_cnt == 0)
            return 1'b0;
         c      = (col_pos >= w) ? 0 : col_pos;
         in_pix = (item.cmd == CMD_FLUSH) ? OUTSIDE_CELL : {1'b0, item.pixel};
         // rows above the frame are outside
         top  = (row_pos < 2) ? OUTSIDE_CELL : upper_line[c];
         mid  = (row_pos < 1) ? OUTSIDE_CELL : middle_line[c];
         upper_line[c]  = mid;
         middle_line[c] = in_pix;
         for (r = 0; r < 3; r++) begin
            win[r*3]   = win[r*3+1];
            win[r*3+1] = win[r*3+2];
         end
         win[2] = top;
         win[5] = mid;
         win[8] = in_pix;
         cc   = (c == 0) ? w - 1 : c - 1;
         emit = (warm_cnt >= w + 1) && !win[4][PIXEL_BITS];
         if (warm_cnt < w + 1) warm_cnt++;
         if (item.cmd == CMD_FLUSH) begin
            if (flush_cnt < w + 1) flush_cnt++;
         end else begin
            flush_cnt = 0;
         end
         fin = (item.cmd == CMD_FLUSH) && (flush_cnt >= w + 1);
         if (emit) begin
            sum = 0;
            cnt = 0;
            for (i = 0; i < NB_COUNT; i++) begin
               v = win[(i < 4) ? i : i + 1];
               if (nb_mask[i] && !(LOOKS_WEST[i] && cc == 0) &&
                   !(LOOKS_EAST[i] && cc == w - 1) && !v[PIXEL_BITS]) begin
                  sum += v[PIXEL_BITS-1:0];
                  cnt++;
               end
            end
            avg  = (cnt > 0) ? sum / cnt : 0;
            prod = (avg * gain) >> GAIN_FRAC;
            res.value = (prod > 255) ? 8'hFF : prod[OUT_BITS-1:0];
            res.last  = fin;
            pending_means = {pending_means, res};
         end
         // raster position; row count saturates
         c++;
         if (c >= w) begin
            c = 0;
            if (row_pos != '1) row_pos++;
         end
         col_pos = c;
         if (fin) restart_frame();
         return 1'b1;
      endfunction

      task report_mismatch(string what);
         errors++;
         $display("[%0t] mismatch: %s", $time, what);
      endtask

      task check_value(rsp_payload_type got);
         rsp_payload_type want;
         if (pending_means.size() == 0) begin
            report_mismatch($sformatf("unexpected result value=%0d last=%0b",
                                      got.value, got.last));
            return;
         end
         want = pending_means.pop_front();
         checked++;
         if (got.value !== want.value)
            report_mismatch($sformatf("value %0d, predicted %0d", got.value, want.value));
         if (got.last !== want.last)
            report_mismatch($sformatf("last %0b, predicted %0b", got.last, want.last));
         if (want.last) frames_done++;
      endtask
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   req_payload_type               req_data = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   rsp_payload_type               rsp_data;
   logic                          psel = 1'b0;
   logic                          penable = 1'b0;
   logic                          pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0]      paddr = '0;
   logic [CSR_DATA_BITS-1:0]      pwdata = '0;
   logic [CSR_DATA_BITS-1:0]      prdata;
   logic                          pready;

   neighbour_mean_scoreboard sb;
   bit quiet = 1'b0;
   int items_sent = 0;
   int settings_seen = 0;
   int stall_hold = 0;

   masked_neighbour_mean_filter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver stalls: mostly short, a few long, long ready stretches too
   always @(negedge clock) begin
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
      end else if (rsp_stall) begin
         rsp_stall  <= 1'b0;
         stall_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                   : $urandom_range(0, 8);
      end else begin
         rsp_stall  <= 1'b1;
         stall_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 2);
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_value(rsp_data);
   end

   function automatic int sender_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [PIXEL_BITS-1:0] pick_pixel();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return PIXEL_BITS'($urandom_range(0, 255));
   endfunction

   // random bits above the register width
   function automatic logic [CSR_DATA_BITS-1:0] add_junk(logic [CSR_DATA_BITS-1:0] v,
                                                         int bits);
      if ($urandom_range(0, 1) == 0) return v;
      return v | (($urandom() >> bits) << bits);
   endfunction

   task automatic send_item(input logic cmd, input logic [PIXEL_BITS-1:0] pix);
      req_payload_type item;
      int gap;
      item.cmd   = cmd;
      item.pixel = pix;
      gap = sender_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      if (sb.note_item(item)) begin
         items_sent++;
      end
   endtask

   // flushes enough to close any open frame
   task automatic end_frame();
      repeat (sb.eff_width() + 1) send_item(CMD_FLUSH, pick_pixel());
   endtask

   // wait until every predicted result is back and the block is quiet
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending_means.size() != 0) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   task automatic write_reg(input csr_reg_type r, input logic [CSR_DATA_BITS-1:0] v);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {r, 2'b00};
      pwdata  <= v;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_reg(r, v);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic check_reg(input csr_reg_type r);
      logic [CSR_DATA_BITS-1:0] want;
      want = sb.reg_value(r);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {r, 2'b00};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want)
         sb.report_mismatch($sformatf("%s reads %0d, holds %0d", r.name(), prdata, want));
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // narrowing the row is safe mid-frame; widening never is
   task automatic shrink_midframe();
      settle();
      write_reg(REG_ROW_WIDTH, $urandom_range(0, sb.eff_width()));
      write_reg(REG_NEIGHBOUR_MASK, $urandom_range(0, 255));
      write_reg(REG_GAIN, $urandom_range(0, 4095));
   endtask

   task automatic send_frame(input int n, input bit messy);
      int  lead, cut_at, burst, i, w;
      bit  noisy;
      noisy  = messy && ($urandom_range(0, 7) == 0);
      cut_at = -1;
      if (messy && $urandom_range(0, 4) == 0) cut_at = $urandom_range(1, n);
      lead = (messy && $urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
      repeat (lead) send_item(CMD_FLUSH, pick_pixel());
      for (i = 0; i < n; i++) begin
         if (i == cut_at) shrink_midframe();
         if (noisy && $urandom_range(0, 2) == 0) begin
            send_item(CMD_FLUSH, pick_pixel());
         end else begin
            // partial flush, then the raster goes on
            if (messy && $urandom_range(0, 19) == 0) begin
               w = sb.eff_width();
               burst = ($urandom_range(0, 3) == 0) ? w : $urandom_range(1, (w > 6) ? 6 : w);
               repeat (burst) send_item(CMD_FLUSH, pick_pixel());
            end
            send_item(CMD_PIXEL, pick_pixel());
         end
      end
      end_frame();
   endtask

   task automatic run_phase(input int phase);
      logic [CSR_DATA_BITS-1:0] wv, mv, gv;
      int  r, frames, n, w;
      bit  big;
      settle();
      big = (phase == 2);
      if (big) wv = ($urandom_range(0, 1) == 0) ? MAX_ROW_WIDTH : 2047;
      else if (phase == 4) wv = 1;
      else if ($urandom_range(0, 19) == 0) wv = 0;
      else if ($urandom_range(0, 5) == 0) wv = $urandom_range(9, 40);
      else wv = $urandom_range(1, 8);
      r  = $urandom_range(0, 9);
      mv = (r == 0) ? 0 : (r < 4) ? 255 : $urandom_range(1, 254);
      r  = $urandom_range(0, 9);
      gv = (r == 0) ? 0 : (r == 1) ? 4095 : (r < 4) ? 256 :
           (r < 7) ? $urandom_range(1, 511) : $urandom_range(1, 4094);
      write_reg(REG_ROW_WIDTH, add_junk(wv, WIDTH_BITS));
      write_reg(REG_NEIGHBOUR_MASK, add_junk(mv, MASK_BITS));
      write_reg(REG_GAIN, add_junk(gv, GAIN_BITS));
      check_reg(REG_ROW_WIDTH);
      check_reg(REG_NEIGHBOUR_MASK);
      check_reg(REG_GAIN);
      settings_seen++;
      quiet = (phase == 4) || ($urandom_range(0, 4) == 0);
      if (phase == 4) begin
         // one-pixel rows with flushes in between
         repeat (40) begin
            send_item(CMD_PIXEL, pick_pixel());
            send_item(CMD_FLUSH, pick_pixel());
         end
         end_frame();
      end else if (big) begin
         // part of one full-depth row, drained by a full flush
         send_frame($urandom_range(8, 60), 1'b0);
      end else begin
         frames = $urandom_range(1, 3);
         repeat (frames) begin
            if (items_sent < ITEM_TARGET) begin
               w = sb.eff_width();
               n = w * $urandom_range(1, 6) + $urandom_range(0, w);
               send_frame(n, 1'b1);
            end
         end
      end
      quiet = 1'b0;
   endtask

   initial begin
      #400_000_000;
      $display("timeout: result stream stopped");
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int phase;
      sb = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values
      check_reg(REG_ROW_WIDTH);
      check_reg(REG_NEIGHBOUR_MASK);
      check_reg(REG_GAIN);

      // directed: 3-wide frame with edge pixels, idle flush, partial flush
      write_reg(REG_ROW_WIDTH, 32'd3);
      write_reg(REG_NEIGHBOUR_MASK, 32'hFF);
      write_reg(REG_GAIN, 32'd256);
      send_item(CMD_FLUSH, 8'h5A);
      send_item(CMD_PIXEL, 8'd0);
      send_item(CMD_PIXEL, 8'd255);
      send_item(CMD_PIXEL, 8'd128);
      send_item(CMD_PIXEL, 8'd255);
      send_item(CMD_PIXEL, 8'd0);
      send_item(CMD_PIXEL, 8'd1);
      send_item(CMD_FLUSH, 8'h00);
      send_item(CMD_FLUSH, 8'hFF);
      send_item(CMD_PIXEL, 8'd77);
      send_item(CMD_PIXEL, 8'd200);
      end_frame();
      settle();

      // directed: zero width acts as one, max gain, sparse mask
      write_reg(REG_ROW_WIDTH, 32'd0);
      write_reg(REG_NEIGHBOUR_MASK, 32'h5A);
      write_reg(REG_GAIN, 32'd4095);
      send_item(CMD_PIXEL, 8'd255);
      send_item(CMD_PIXEL, 8'd255);
      send_item(CMD_PIXEL, 8'd0);
      end_frame();
      settings_seen += 2;

      // random frames under changing settings
      phase = 0;
      while (items_sent < ITEM_TARGET || phase < 4) begin
         phase++;
         run_phase(phase);
      end

      settle();
      repeat (40) @(posedge clock);
      $display("Ran %0d transactions, %0d results checked, %0d frame ends, %0d settings;",
               items_sent, sb.checked, sb.frames_done, settings_seen);
      $display("zero, one-pixel and clamped full-depth rows, mid-frame narrowing, flushes.");
      if (sb.errors == 0 && sb.pending_means.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
